/* rtl/cdcl_pkg.sv */
// ---------------------------------------------------------------------------
// cdcl_pkg: shared constants of the duty-cycle limiter
// Field widths, register indexes, reset values and datapath sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdcl_pkg;

    localparam int WINDOW_DEF = 10;

    localparam int LIM_W  = 7;
    localparam int PER_W  = 20;
    localparam int HZ_W   = 14;
    localparam int TICK_W = 32;
    localparam int TIME_W = 48;
    localparam int QNT_W  = 22;
    localparam int Q16_W  = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_HZ = 2'd2;

    localparam logic [LIM_W-1:0] LIM_RST = 7'd100;
    localparam logic [PER_W-1:0] PER_RST = 20'd100000;
    localparam logic [HZ_W-1:0]  HZ_RST  = 14'd100;

    localparam logic [LIM_W-1:0] PCT_FULL   = 7'd100;
    localparam logic [19:0]      US_PER_S   = 20'd1000000;
    localparam logic [26:0]      PCT_SCALE  = 27'd100000000;
    localparam logic [Q16_W-1:0] Q_MAX      = '1;

    // divider sizes
    localparam int NUM_W = 70;
    localparam int DEN_W = 62;
    localparam int QB    = 24;

endpackage

`default_nettype wire

/* rtl/cdcl_req_if.sv */
// ---------------------------------------------------------------------------
// cdcl_req_if: request channel of the duty-cycle limiter
// Valid/ready handshake carrying one control-period sample.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdcl_req_if;
    import cdcl_pkg::*;

    logic                valid;
    logic                ready;
    logic                kind;
    logic                sample_ok;
    logic [TICK_W-1:0]   busy_ticks;
    logic [TIME_W-1:0]   now_us;
    logic [QNT_W-1:0]    last_work_us;

    modport source (output valid, kind, sample_ok, busy_ticks, now_us, last_work_us,
                    input ready);
    modport sink   (input valid, kind, sample_ok, busy_ticks, now_us, last_work_us,
                    output ready);
endinterface

`default_nettype wire

/* rtl/cdcl_res_if.sv */
// ---------------------------------------------------------------------------
// cdcl_res_if: result channel of the duty-cycle limiter
// Valid/ready handshake carrying estimates and the next work/sleep slices.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdcl_res_if;
    import cdcl_pkg::*;

    logic               valid;
    logic               ready;
    logic               dead;
    logic               first_sample;
    logic [Q16_W-1:0]   usage_q16;
    logic [Q16_W-1:0]   rate_q16;
    logic [PER_W-1:0]   work_us;
    logic [PER_W-1:0]   sleep_us;
    logic               resume_target;
    logic               stop_target;

    modport source (output valid, dead, first_sample, usage_q16, rate_q16, work_us,
                    sleep_us, resume_target, stop_target, input ready);
    modport sink   (input valid, dead, first_sample, usage_q16, rate_q16, work_us,
                    sleep_us, resume_target, stop_target, output ready);
endinterface

`default_nettype wire

/* rtl/cdcl_ram.sv */
// ---------------------------------------------------------------------------
// cdcl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

/* rtl/cpu_duty_cycle_limiter_core.sv */
// Requests are taken one at a time. A full estimate runs up to three passes of the
//   shared restoring divider plus shared-multiplier steps; the first-sample /
//   zero-interval case uses reciprocal multiplies only; an unreadable sample goes
//   straight to the result.
// Reset (synchronous, active low): window empty, config at 100 %, 100 ms, 100 Hz,
//   no result pending. The sample ring RAM holds no reset value.
// ---------------------------------------------------------------------------
// cpu_duty_cycle_limiter_core: CPU duty-cycle limiter
// Keeps a ring of recent samples, estimates usage and working rate and issues
// the next work/sleep slices through a sequencer over one multiplier and one
// divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpu_duty_cycle_limiter_core #(
    parameter int WINDOW = cdcl_pkg::WINDOW_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cdcl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cdcl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cdcl_req_if.sink                            i_req,
    cdcl_res_if.source                          o_res
);
    import cdcl_pkg::*;

    localparam int IW  = $clog2(WINDOW);
    localparam int SW  = QNT_W + IW;            // sum of quanta in the window
    localparam int AW  = LIM_W + HZ_W + SW;     // limit * sum * tick rate
    localparam int EW  = QNT_W + TIME_W + TICK_W;
    localparam int DSW = DEN_W + QB;
    localparam logic [IW-1:0] LAST = IW'(WINDOW - 1);

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SH for any 32-bit x
    localparam logic [31:0] RECIP_100 = 32'd1374389535;
    localparam int          RECIP_SH  = 37;

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_WR    = 5'd1;
    localparam logic [4:0] S_RD    = 5'd2;
    localparam logic [4:0] S_CHK   = 5'd3;
    localparam logic [4:0] S_DSAT  = 5'd4;
    localparam logic [4:0] S_DSTEP = 5'd5;
    localparam logic [4:0] S_M1    = 5'd6;
    localparam logic [4:0] S_M2    = 5'd7;
    localparam logic [4:0] S_M3    = 5'd8;
    localparam logic [4:0] S_M4    = 5'd9;
    localparam logic [4:0] S_W1    = 5'd10;
    localparam logic [4:0] S_W2    = 5'd11;
    localparam logic [4:0] S_W3    = 5'd12;
    localparam logic [4:0] S_W4    = 5'd13;
    localparam logic [4:0] S_W5    = 5'd14;
    localparam logic [4:0] S_W6    = 5'd15;
    localparam logic [4:0] S_F1    = 5'd16;
    localparam logic [4:0] S_F2    = 5'd17;
    localparam logic [4:0] S_DROP  = 5'd18;
    localparam logic [4:0] S_SUB   = 5'd19;
    localparam logic [4:0] S_FIN   = 5'd20;
    localparam logic [4:0] S_F3    = 5'd21;
    localparam logic [4:0] S_F4    = 5'd22;

    // divider result destinations
    localparam logic [2:0] D_RATE  = 3'd0;
    localparam logic [2:0] D_USAGE = 3'd1;
    localparam logic [2:0] D_WORK  = 3'd2;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
        return (x == LAST) ? '0 : x + 1'b1;
    endfunction

    // configuration
    logic [LIM_W-1:0] r_lim;
    logic [PER_W-1:0] r_per;
    logic [HZ_W-1:0]  r_hz;

    // control
    logic [4:0]    r_state;
    logic [IW-1:0] r_newest;
    logic [IW-1:0] r_oldest;
    logic          r_nvalid;
    logic          r_ov;

    // captured request and window bookkeeping
    logic [TICK_W-1:0] r_tick;
    logic [TIME_W-1:0] r_time;
    logic [QNT_W-1:0]  r_qnt;
    logic [SW-1:0]     r_sum;
    logic              r_full;
    logic              r_first;
    logic              r_dead;
    logic [TIME_W-1:0] r_dt;
    logic [TICK_W-1:0] r_used;

    // shared datapath
    logic [63:0]      r_prod;
    logic [AW-1:0]    r_a;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_rem;
    logic [DSW-1:0]   r_ds;
    logic [QB-1:0]    r_quo;
    logic [4:0]       r_cnt;
    logic [2:0]       r_dsel;

    logic [Q16_W-1:0] r_usage;
    logic [Q16_W-1:0] r_rate;
    logic [PER_W-1:0] r_work;

    // output register
    logic             r_o_dead;
    logic             r_o_first;
    logic [Q16_W-1:0] r_o_usage;
    logic [Q16_W-1:0] r_o_rate;
    logic [PER_W-1:0] r_o_work;
    logic [PER_W-1:0] r_o_sleep;
    logic             r_o_resume;
    logic             r_o_stop;

    // effective limit and tick rate
    logic [LIM_W-1:0] eff_lim;
    logic [HZ_W-1:0]  eff_hz;
    assign eff_lim = (r_lim > PCT_FULL) ? PCT_FULL : r_lim;
    assign eff_hz  = (r_hz == '0) ? HZ_W'(1) : r_hz;

    // sample ring: {quantum, time, ticks}
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic [IW-1:0] n_newest;
    logic [IW-1:0] n_oldest;

    assign n_newest  = r_nvalid ? wrap_inc(r_newest) : '0;
    assign n_oldest  = r_nvalid ? r_oldest : '0;
    assign ram_we    = (r_state == S_WR);
    assign ram_waddr = n_newest;

    always_comb begin
        case (r_state)
            S_WR:    ram_raddr = n_oldest;
            S_DROP:  ram_raddr = wrap_inc(r_oldest);
            default: ram_raddr = r_oldest;
        endcase
    end

    cdcl_ram #(
        .WIDTH (EW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_qnt, r_time, r_tick}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic [TICK_W-1:0] rd_tick;
    logic [TIME_W-1:0] rd_time;
    logic [QNT_W-1:0]  rd_qnt;
    assign rd_tick = ram_rdata[TICK_W-1:0];
    assign rd_time = ram_rdata[TICK_W +: TIME_W];
    assign rd_qnt  = ram_rdata[TICK_W+TIME_W +: QNT_W];

    // shared 32x32 multiplier, operands picked by the sequencer
    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [63:0] m_p;

    always_comb begin
        case (r_state)
            S_M1: begin
                m_a = r_used;
                m_b = 32'(US_PER_S);
            end
            S_M2: begin
                m_a = r_dt[31:0];
                m_b = 32'(eff_hz);
            end
            S_M3: begin
                m_a = 32'(r_dt[TIME_W-1:32]);
                m_b = 32'(eff_hz);
            end
            S_W1: begin
                m_a = 32'(eff_lim);
                m_b = 32'(eff_hz);
            end
            S_W2: begin
                m_a = 32'(r_prod[LIM_W+HZ_W-1:0]);
                m_b = 32'(r_sum);
            end
            S_W3: begin
                m_a = r_used;
                m_b = 32'(PCT_SCALE);
            end
            S_W4: begin
                m_a = r_a[31:0];
                m_b = 32'(r_per);
            end
            S_W5: begin
                m_a = 32'(r_a[AW-1:32]);
                m_b = 32'(r_per);
            end
            S_F1: begin
                m_a = 32'({eff_lim, 16'b0});
                m_b = RECIP_100;
            end
            S_F2: begin
                m_a = 32'(eff_lim);
                m_b = 32'(r_per);
            end
            S_F3: begin
                m_a = r_prod[31:0];
                m_b = RECIP_100;
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign m_p = m_a * m_b;

    // shared restoring divider: one quotient bit per cycle
    logic             d_ge;
    logic             d_done;
    logic [QB-1:0]    d_res;

    assign d_ge   = DSW'(r_rem) >= r_ds;
    assign d_done = ((r_state == S_DSAT) && d_ge) || ((r_state == S_DSTEP) && (r_cnt == 5'd1));
    assign d_res  = (r_state == S_DSAT) ? Q_MAX : {r_quo[QB-2:0], d_ge};

    // handshake
    assign i_req.ready = (r_state == S_IDLE);
    logic req_acc;
    assign req_acc = i_req.valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim    <= LIM_RST;
            r_per    <= PER_RST;
            r_hz     <= HZ_RST;
            r_state  <= S_IDLE;
            r_newest <= '0;
            r_oldest <= '0;
            r_nvalid <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_prod <= m_p;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIMIT:   r_lim <= i_cfg_data[LIM_W-1:0];
                    CFG_PERIOD:  r_per <= i_cfg_data[PER_W-1:0];
                    CFG_TICK_HZ: r_hz  <= i_cfg_data[HZ_W-1:0];
                    default: ;
                endcase
            end

            // release the result once taken
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            // shared divider stepping
            if (r_state == S_DSAT && !d_ge) begin
                r_ds    <= r_ds >> 1;
                r_cnt   <= 5'(QB);
                r_state <= S_DSTEP;
            end
            if (r_state == S_DSTEP) begin
                if (d_ge) begin
                    r_rem <= r_rem - r_ds[NUM_W-1:0];
                end
                r_quo <= {r_quo[QB-2:0], d_ge};
                r_ds  <= r_ds >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            if (d_done) begin
                case (r_dsel)
                    D_RATE: begin
                        r_rate <= d_res;
                        if (r_used == '0) begin
                            r_usage <= '0;
                            r_work  <= r_per;
                            r_state <= S_DROP;
                        end else begin
                            r_state <= S_M1;
                        end
                    end
                    D_USAGE: begin
                        r_usage <= d_res;
                        r_state <= S_W1;
                    end
                    D_WORK: begin
                        r_work  <= d_res[PER_W-1:0];
                        r_state <= S_DROP;
                    end
                    default: r_state <= S_DROP;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_tick <= i_req.busy_ticks;
                        r_time <= i_req.now_us;
                        r_qnt  <= i_req.last_work_us;
                        r_dead <= 1'b0;
                        if (i_req.kind) begin
                            // restart: empty the window, no result
                            r_nvalid <= 1'b0;
                            r_newest <= '0;
                            r_oldest <= '0;
                        end else if (!i_req.sample_ok) begin
                            // unreadable sample: empty the window, report dead
                            r_nvalid <= 1'b0;
                            r_newest <= '0;
                            r_oldest <= '0;
                            r_dead   <= 1'b1;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    // store the sample and fetch the oldest one
                    r_newest <= n_newest;
                    r_oldest <= n_oldest;
                    r_nvalid <= 1'b1;
                    r_first  <= !r_nvalid;
                    r_sum    <= r_nvalid ? r_sum + SW'(r_qnt) : '0;
                    r_full   <= (wrap_inc(n_newest) == n_oldest);
                    r_state  <= S_RD;
                end
                S_RD: begin
                    r_dt    <= r_time - rd_time;
                    r_used  <= r_tick - rd_tick;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_quo <= '0;
                    if (r_first || (r_dt == '0) || (r_sum == '0)) begin
                        // first sample or empty interval: both estimates at the limit
                        r_state <= S_F1;
                    end else begin
                        r_rem   <= NUM_W'({r_sum, 16'b0});
                        r_ds    <= {DEN_W'(r_dt), QB'(0)};
                        r_dsel  <= D_RATE;
                        r_state <= S_DSAT;
                    end
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_rem   <= NUM_W'({r_prod, 16'b0});
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_den   <= r_prod[DEN_W-1:0];
                    r_state <= S_M4;
                end
                S_M4: begin
                    // usage = used * 1e6 / (hz * dt)
                    r_ds    <= {r_den + {r_prod[DEN_W-33:0], 32'b0}, QB'(0)};
                    r_quo   <= '0;
                    r_dsel  <= D_USAGE;
                    r_state <= S_DSAT;
                end
                S_W1: r_state <= S_W2;
                S_W2: r_state <= S_W3;
                S_W3: begin
                    r_a     <= r_prod[AW-1:0];
                    r_state <= S_W4;
                end
                S_W4: begin
                    // cap the work slice at one period when a >= b
                    if (64'(r_a) >= r_prod) begin
                        r_work  <= r_per;
                        r_state <= S_DROP;
                    end else begin
                        r_den   <= r_prod[DEN_W-1:0];
                        r_state <= S_W5;
                    end
                end
                S_W5: begin
                    r_rem   <= NUM_W'(r_prod);
                    r_state <= S_W6;
                end
                S_W6: begin
                    r_rem   <= r_rem + NUM_W'({r_prod[NUM_W-33:0], 32'b0});
                    r_ds    <= {r_den, QB'(0)};
                    r_quo   <= '0;
                    r_dsel  <= D_WORK;
                    r_state <= S_DSAT;
                end
                S_F1: r_state <= S_F2;
                S_F2: begin
                    // limit * 65536 / 100 by reciprocal multiply
                    r_usage <= r_prod[RECIP_SH +: Q16_W];
                    r_rate  <= r_prod[RECIP_SH +: Q16_W];
                    r_state <= S_F3;
                end
                S_F3: r_state <= S_F4;
                S_F4: begin
                    // period * limit / 100 by reciprocal multiply
                    r_work  <= r_prod[RECIP_SH +: PER_W];
                    r_state <= S_DROP;
                end
                S_DROP: begin
                    // full window: drop the oldest, fetch the new oldest quantum
                    r_state <= (r_full && !r_first) ? S_SUB : S_FIN;
                end
                S_SUB: begin
                    r_sum    <= r_sum - SW'(rd_qnt);
                    r_oldest <= wrap_inc(r_oldest);
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ov || o_res.ready) begin
                        r_ov       <= 1'b1;
                        r_o_dead   <= r_dead;
                        r_o_first  <= r_dead ? 1'b0 : r_first;
                        r_o_usage  <= r_dead ? '0 : r_usage;
                        r_o_rate   <= r_dead ? '0 : r_rate;
                        r_o_work   <= r_dead ? '0 : r_work;
                        r_o_sleep  <= r_dead ? '0 : r_per - r_work;
                        r_o_resume <= r_dead ? 1'b0 : (eff_lim != '0) && (eff_lim < PCT_FULL);
                        r_o_stop   <= r_dead ? 1'b0 : (eff_lim < PCT_FULL);
                        r_state    <= S_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.dead          = r_o_dead;
    assign o_res.first_sample  = r_o_first;
    assign o_res.usage_q16     = r_o_usage;
    assign o_res.rate_q16      = r_o_rate;
    assign o_res.work_us       = r_o_work;
    assign o_res.sleep_us      = r_o_sleep;
    assign o_res.resume_target = r_o_resume;
    assign o_res.stop_target   = r_o_stop;

`ifndef SYNTHESIS
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.dead) |-> (o_res.work_us == '0 && o_res.usage_q16 == '0))
        else $error("dead result carries nonzero fields");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSTEP) |-> (r_cnt != '0 && r_cnt <= 5'(QB)))
        else $error("divider step count out of range");

    a_ring_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nvalid |-> (r_newest <= LAST && r_oldest <= LAST))
        else $error("ring index beyond window");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB) |-> (r_full && !r_first))
        else $error("oldest sample dropped from a window that is not full");

    a_work_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_dead) |-> (r_work <= r_per))
        else $error("work slice exceeds the period");
`endif

endmodule

`default_nettype wire
